// ===== hdl/gaussian_field_profile_evaluator_core_macros.svh =====
// Assertion macros shared by the checker of the Gaussian field profile core.
// No dependencies.
`ifndef GAUSSIAN_FIELD_PROFILE_EVALUATOR_CORE_MACROS_SVH
`define GAUSSIAN_FIELD_PROFILE_EVALUATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GFP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define GFP_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/gfp_eval_pkg.sv =====
// Package for the Gaussian field profile core: table depth default,
// register indexes and the elaboration-time exponential table builder.
`timescale 1ns / 1ps
package gfp_eval_pkg;

    localparam int unsigned EXP_TABLE_DEPTH_DEF = 256;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 48;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PEAK_X   = 3'd0,
        REG_PEAK_Y   = 3'd1,
        REG_PEAK_Z   = 3'd2,
        REG_CENTER_X = 3'd3,
        REG_CENTER_Y = 3'd4,
        REG_CENTER_Z = 3'd5,
        REG_INV_W    = 3'd6
    } t_reg_index;

    // exp(-r) in Q2.30, 0 <= r <= 1.0, by a 21-term series
    function automatic longint taylor_exp_neg(longint R);
        longint term;
        longint acc;
        term = longint'(1) << 30;
        acc = term;
        for (int K = 1; K <= 20; K++) begin
            term = longint'((longint'(unsigned'(term) * unsigned'(R)) >>> 30) / K);
            if (K % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        return acc;
    endfunction

    // Table entry exp(-16*Idx/Depth) in Q1.16, rounded half up
    function automatic logic [16:0] exp_entry(int unsigned Idx, int unsigned Depth);
        longint em1;
        longint v;
        longint num;
        longint whole;
        longint rem;
        em1 = taylor_exp_neg(longint'(1) << 30);
        num = 16 * longint'(Idx);
        whole = num / Depth;
        rem = num % Depth;
        v = taylor_exp_neg((rem <<< 30) / Depth);
        if (v < 0) begin
            v = 0;
        end
        for (int N = 0; N < 16; N++) begin
            if (N < whole) begin
                v = (v * em1) >>> 30;
            end
        end
        return 17'((v + (longint'(1) << 13)) >>> 14);
    endfunction

endpackage

// ===== hdl/gaussian_field_profile_evaluator_core.sv =====
// Top level of the Gaussian field profile core: ten-stage pipeline.
// Depends on gfp_eval_pkg.
//
// Channel   Direction  Handshake          Payload
// query     in         i_valid / o_stall  i_pos_x, i_pos_y, i_pos_z
// result    out        o_valid / i_stall  o_field_out_x/y/z, o_weight
// config    in         i_cfg_wr_en        i_cfg_index, i_cfg_data
//
// One query per cycle unless the result side stalls; the ten register
// stages are difference, width multiply, square, sum, table address, table
// read, slope multiply, interpolate, field multiply and clamp.
// Each stage advances when the one after it is empty or advancing, so
// bubbles close up and a stall on the result side holds every transaction.
// Reset (synchronous, active low) clears the stage valid bits and the
// configuration registers; stage data registers are not reset.
`timescale 1ns / 1ps
module gaussian_field_profile_evaluator_core #(
    parameter int unsigned EXP_TABLE_DEPTH = gfp_eval_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [31:0]                    i_pos_x,
    input  logic signed [31:0]                    i_pos_y,
    input  logic signed [31:0]                    i_pos_z,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [31:0]                    o_field_out_x,
    output logic signed [31:0]                    o_field_out_y,
    output logic signed [31:0]                    o_field_out_z,
    output logic [16:0]                           o_weight,
    input  logic                                  i_cfg_wr_en,
    input  logic [gfp_eval_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [gfp_eval_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gfp_eval_pkg::*;

    localparam int unsigned NS = 10;
    localparam int unsigned IW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int unsigned DW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int unsigned PW = 20 + DW;

    // configuration
    logic signed [31:0] r_peak [3];
    logic signed [31:0] r_center [3];
    logic [47:0]        r_inv_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_peak[a] <= '0;
                r_center[a] <= '0;
            end
            r_inv_w <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_index))
                REG_PEAK_X:   r_peak[0] <= i_cfg_data[31:0];
                REG_PEAK_Y:   r_peak[1] <= i_cfg_data[31:0];
                REG_PEAK_Z:   r_peak[2] <= i_cfg_data[31:0];
                REG_CENTER_X: r_center[0] <= i_cfg_data[31:0];
                REG_CENTER_Y: r_center[1] <= i_cfg_data[31:0];
                REG_CENTER_Z: r_center[2] <= i_cfg_data[31:0];
                REG_INV_W:    r_inv_w <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // exponential table, constant logic
    logic [16:0] w_lut [EXP_TABLE_DEPTH+1];
    for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_lut
        assign w_lut[g] = exp_entry(g, EXP_TABLE_DEPTH);
    end

    // stage valid bits and advance enables
    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: difference from center
    logic signed [32:0] r_s1_d [3];
    logic signed [31:0] w_pos [3];
    assign w_pos[0] = i_pos_x;
    assign w_pos[1] = i_pos_y;
    assign w_pos[2] = i_pos_z;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int a = 0; a < 3; a++) begin
                r_s1_d[a] <= 33'(w_pos[a]) - 33'(r_center[a]);
            end
        end
    end

    // stage 2: |d| * inverse width
    logic [48:0] r_s2_prod [3];
    logic [2:0]  r_s2_on;
    logic [32:0] w_mag [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = r_s1_d[a][32] ? 33'(-r_s1_d[a]) : 33'(r_s1_d[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int a = 0; a < 3; a++) begin
                r_s2_prod[a] <= 49'(w_mag[a]) * 49'(r_inv_w[16*a +: 16]);
                r_s2_on[a] <= (r_inv_w[16*a +: 16] != '0);
            end
        end
    end

    // stage 3: square each term, mark far tail
    logic [20:0] r_s3_term [3];
    logic [2:0]  r_s3_big;
    logic [37:0] w_sq [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sq[a] = 38'(r_s2_prod[a][26:8]) * 38'(r_s2_prod[a][26:8]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int a = 0; a < 3; a++) begin
                r_s3_big[a] <= r_s2_on[a] && (r_s2_prod[a][48:27] != '0);
                r_s3_term[a] <= r_s2_on[a] ? w_sq[a][37:17] : '0;
            end
        end
    end

    // stage 4: sum and flush decision
    logic [19:0] r_s4_sum;
    logic        r_s4_flush;
    logic [22:0] w_sum;
    assign w_sum = 23'(r_s3_term[0]) + 23'(r_s3_term[1]) + 23'(r_s3_term[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_sum <= w_sum[19:0];
            r_s4_flush <= (|r_s3_big) || (w_sum[22:20] != '0);
        end
    end

    // stage 5: table address and fraction
    logic [IW-1:0] r_s5_idx;
    logic [15:0]   r_s5_frac;
    logic          r_s5_flush;
    logic [PW-1:0] w_pf;
    logic [IW-1:0] w_idx;
    assign w_pf = PW'(r_s4_sum) * PW'(EXP_TABLE_DEPTH);
    assign w_idx = IW'(w_pf[PW-1:20]);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_idx <= (w_idx >= IW'(EXP_TABLE_DEPTH)) ? IW'(EXP_TABLE_DEPTH - 1) : w_idx;
            r_s5_frac <= w_pf[19:4];
            r_s5_flush <= r_s4_flush;
        end
    end

    // stage 6: table read
    logic [16:0] r_s6_hi;
    logic [16:0] r_s6_lo;
    logic [15:0] r_s6_frac;
    logic        r_s6_flush;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_hi <= w_lut[r_s5_idx];
            r_s6_lo <= w_lut[IW'(r_s5_idx + 1'b1)];
            r_s6_frac <= r_s5_frac;
            r_s6_flush <= r_s5_flush;
        end
    end

    // stage 7: slope times fraction
    logic [16:0] r_s7_hi;
    logic [32:0] r_s7_dp;
    logic        r_s7_flush;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s7_hi <= r_s6_hi;
            r_s7_dp <= 33'(17'(r_s6_hi - r_s6_lo)) * 33'(r_s6_frac);
            r_s7_flush <= r_s6_flush;
        end
    end

    // stage 8: interpolated weight
    logic [16:0] r_s8_w;

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s8_w <= r_s7_flush ? '0 : 17'(r_s7_hi - r_s7_dp[32:16]);
        end
    end

    // stage 9: peak times weight
    logic signed [49:0] r_s9_fp [3];
    logic [16:0]        r_s9_w;

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            for (int a = 0; a < 3; a++) begin
                r_s9_fp[a] <= 50'(r_peak[a]) * signed'({33'd0, r_s8_w});
            end
            r_s9_w <= r_s8_w;
        end
    end

    // stage 10: floor shift and clamp
    logic signed [31:0] r_out_f [3];
    logic [16:0]        r_out_w;
    logic signed [33:0] w_sh [3];
    logic signed [31:0] w_cl [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sh[a] = 34'(r_s9_fp[a] >>> 16);
            if (w_sh[a] > 34'sd2147483647) begin
                w_cl[a] = 32'sh7FFFFFFF;
            end else if (w_sh[a] < -34'sd2147483648) begin
                w_cl[a] = 32'sh80000000;
            end else begin
                w_cl[a] = w_sh[a][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[9]) begin
            for (int a = 0; a < 3; a++) begin
                r_out_f[a] <= w_cl[a];
            end
            r_out_w <= r_s9_w;
        end
    end

    assign o_field_out_x = r_out_f[0];
    assign o_field_out_y = r_out_f[1];
    assign o_field_out_z = r_out_f[2];
    assign o_weight = r_out_w;

endmodule

// ===== hdl/gfp_eval_checker.sv =====
// Port-level checker for the Gaussian field profile core, with its bind.
// Depends on gaussian_field_profile_evaluator_core_macros.svh.
`timescale 1ns / 1ps
`include "gaussian_field_profile_evaluator_core_macros.svh"
module gfp_eval_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_field_out_x,
    input logic signed [31:0] o_field_out_y,
    input logic signed [31:0] o_field_out_z,
    input logic [16:0]        o_weight
);
    // a zero weight scales the whole vector away
    `GFP_ASSERT_IMPLY(a_zero_w, i_clk, i_rst_n, o_valid && o_weight == 17'd0, o_field_out_x == 32'sd0 && o_field_out_y == 32'sd0 && o_field_out_z == 32'sd0)
    `GFP_ASSERT_IMPLY(a_w_max, i_clk, i_rst_n, o_valid, o_weight <= 17'd65536)
    `GFP_ASSERT_NEXT(a_rst_empty, i_clk, !i_rst_n, !o_valid)
    // hold a stalled result transaction
    `GFP_ASSERT_NEXT(a_hold, i_clk, i_rst_n && o_valid && i_stall, o_valid && $stable(o_weight) && $stable(o_field_out_x))
endmodule

bind gaussian_field_profile_evaluator_core gfp_eval_checker u_gfp_eval_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for gaussian_field_profile_evaluator_core.
// Depends on gfp_eval_pkg and the core; all queries are checked against a scoreboard.
`timescale 1ns / 1ps
module testbench;
    import gfp_eval_pkg::*;

    localparam int unsigned LUT_DEPTH = EXP_TABLE_DEPTH_DEF;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam longint Q30_UNIT = longint'(1) << 30;

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] fz;
        logic [16:0]        w;
    } field_result_t;

    class field_scoreboard;
        logic [16:0]   exp_lut[0:LUT_DEPTH];
        longint        peak[3];
        longint        ctr[3];
        logic [47:0]   inv_w;
        field_result_t expected_q[$];
        int            errors;

        // exp(-r), r in Q2.30 between 0 and 1
        function longint exp_neg_q30(longint r);
            longint term;
            longint acc;
            term = Q30_UNIT;
            acc = Q30_UNIT;
            for (int k = 1; k <= 20; k++) begin
                term = ((term * r) >>> 30) / k;
                acc = (k % 2 == 1) ? acc - term : acc + term;
            end
            return acc;
        endfunction

        function new();
            longint em1;
            longint v;
            longint num;
            em1 = exp_neg_q30(Q30_UNIT);
            for (int i = 0; i <= LUT_DEPTH; i++) begin
                num = 16 * longint'(i);
                v = exp_neg_q30(((num % LUT_DEPTH) << 30) / LUT_DEPTH);
                if (v < 0) begin
                    v = 0;
                end
                for (longint n = 0; n < num / LUT_DEPTH; n++) begin
                    v = (v * em1) >>> 30;
                end
                exp_lut[i] = 17'((v + (longint'(1) << 13)) >>> 14);
            end
            for (int a = 0; a < 3; a++) begin
                peak[a] = 0;
                ctr[a] = 0;
            end
            inv_w = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PEAK_X:   peak[0] = longint'(signed'(data[31:0]));
                REG_PEAK_Y:   peak[1] = longint'(signed'(data[31:0]));
                REG_PEAK_Z:   peak[2] = longint'(signed'(data[31:0]));
                REG_CENTER_X: ctr[0] = longint'(signed'(data[31:0]));
                REG_CENTER_Y: ctr[1] = longint'(signed'(data[31:0]));
                REG_CENTER_Z: ctr[2] = longint'(signed'(data[31:0]));
                REG_INV_W:    inv_w = data[47:0];
                default: ;
            endcase
        endfunction

        function logic signed [31:0] scale(longint pk, longint w);
            longint r;
            r = (pk * w) >>> 16;   // floor for both signs
            if (r > 64'sd2147483647) begin
                r = 64'sd2147483647;
            end
            if (r < -64'sd2147483648) begin
                r = -64'sd2147483648;
            end
            return r[31:0];
        endfunction

        function void note_query(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
            longint pos[3];
            longint d;
            longint u;
            longint inv;
            longint sum;
            longint p;
            longint i;
            longint hi;
            longint lo;
            longint w;
            bit flush;
            field_result_t e;
            pos[0] = px;
            pos[1] = py;
            pos[2] = pz;
            sum = 0;
            w = 0;
            flush = 0;
            for (int a = 0; a < 3; a++) begin
                inv = inv_w[16*a +: 16];
                d = pos[a] - ctr[a];
                if (d < 0) begin
                    d = -d;
                end
                if (inv != 0) begin
                    u = (d * inv) >> 8;
                    if (u >= (longint'(8) << 16)) begin
                        flush = 1;
                    end else begin
                        sum += (u * u) >> 17;
                    end
                end
            end
            if (sum >= (longint'(16) << 16)) begin
                flush = 1;
            end
            if (!flush) begin
                p = (sum * LUT_DEPTH) >> 4;
                i = p >> 16;
                if (i >= LUT_DEPTH) begin
                    i = LUT_DEPTH - 1;
                end
                hi = exp_lut[i];
                lo = exp_lut[i+1];
                w = hi - (((hi - lo) * (p & 'hFFFF)) >> 16);
            end
            e.fx = scale(peak[0], w);
            e.fy = scale(peak[1], w);
            e.fz = scale(peak[2], w);
            e.w = w[16:0];
            expected_q.push_back(e);
        endfunction

        function void check_result(field_result_t act);
            field_result_t e;
            if (expected_q.size() == 0) begin
                $error("result with no query outstanding");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (act.fx !== e.fx) begin
                $error("field_out_x expected %0d actual %0d", e.fx, act.fx);
                errors++;
            end
            if (act.fy !== e.fy) begin
                $error("field_out_y expected %0d actual %0d", e.fy, act.fy);
                errors++;
            end
            if (act.fz !== e.fz) begin
                $error("field_out_z expected %0d actual %0d", e.fz, act.fz);
                errors++;
            end
            if (act.w !== e.w) begin
                $error("weight expected %0d actual %0d", e.w, act.w);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [31:0]      i_pos_x;
    logic signed [31:0]      i_pos_y;
    logic signed [31:0]      i_pos_z;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [31:0]      o_field_out_x;
    logic signed [31:0]      o_field_out_y;
    logic signed [31:0]      o_field_out_z;
    logic [16:0]             o_weight;
    logic                    i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    field_scoreboard sb;
    bit idle_enable;
    int stall_hold;
    int quiet_cycles;

    gaussian_field_profile_evaluator_core i_dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Monitor both channels and the watchdog at the rising edge
    always @(posedge i_clk) begin
        field_result_t act;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                sb.note_query(i_pos_x, i_pos_y, i_pos_z);
            end
            if (o_valid && !i_stall) begin
                act.fx = o_field_out_x;
                act.fy = o_field_out_y;
                act.fz = o_field_out_z;
                act.w = o_weight;
                sb.check_result(act);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("testbench: done, errors");
                    $finish;
                end
            end
        end
    end

    // Result side: long hold-offs on request, else random stall bursts if idle_enable
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                i_stall = 1'b1;
                stall_hold--;
            end else if (idle_enable && $urandom_range(0, 11) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Upper data bits are set on purpose: they must be ignored
    task automatic load_profile(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [47:0] inv);
        write_reg(REG_PEAK_X, {16'hA5A5, px});
        write_reg(REG_PEAK_Y, {16'hFFFF, py});
        write_reg(REG_PEAK_Z, {16'h0000, pz});
        write_reg(REG_CENTER_X, {16'h5A5A, cx});
        write_reg(REG_CENTER_Y, {16'h0000, cy});
        write_reg(REG_CENTER_Z, {16'hFFFF, cz});
        write_reg(REG_INV_W, inv);
    endtask

    task automatic drain();
        while (sb.expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic send_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        if (idle_enable && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_pos_x = px;
        i_pos_y = py;
        i_pos_z = pz;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Offset from center that mostly keeps |u| below the flush limit
    function automatic logic [31:0] near_pos(int a);
        longint inv;
        longint lim;
        longint d;
        inv = sb.inv_w[16*a +: 16];
        if (inv == 0 || $urandom_range(0, 7) == 0) begin
            return $urandom;
        end
        lim = (longint'(8) << 24) / inv;
        lim = lim + lim / 8;
        if (lim > 64'h7FFFFFFF) begin
            lim = 64'h7FFFFFFF;
        end
        d = $urandom_range(0, int'(lim));
        if ($urandom_range(0, 1) == 1) begin
            d = -d;
        end
        return 32'(sb.ctr[a] + d);
    endfunction

    function automatic logic [15:0] rand_inv();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h0001;
            3: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        sb = new();
        idle_enable = 1'b1;
        stall_hold = 0;
        quiet_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_pos_x = '0;
        i_pos_y = '0;
        i_pos_z = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Registers at reset: all axes disabled, weight one, zero field
        send_query(32'h7FFFFFFF, 32'h80000000, 32'h00000000);
        send_query(32'h80000000, 32'h7FFFFFFF, 32'h12345678);
        end_burst();
        drain();

        // Unit inverse widths so u equals the offset
        load_profile(32'h7FFFFFFF, 32'h80000000, 32'h00012345, 0, 0, 0, 48'h0100_0100_0100);
        write_reg(CFG_UNUSED_INDEX, 48'hFFFF_FFFF_FFFF);
        send_query(0, 0, 0);                           // at the peak
        send_query(32'h0001_0000, 0, 0);
        send_query(32'hFFFF_0000, 32'h0002_0000, 0);
        send_query(32'h0004_0000, 32'h0004_0000, 0);   // sum exactly at the tail
        send_query(32'h0004_0000, 32'h0003_FFFF, 0);   // just under it
        send_query(32'h0008_0000, 0, 0);               // |u| at the limit
        send_query(32'h0007_FFFF, 0, 0);               // |u| under, sum over
        send_query(32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
        send_query(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        send_query(32'h80000000, 0, 0);
        send_query(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000);
        end_burst();
        drain();

        // One axis disabled, extreme center, widest inverse width
        load_profile(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF,
                     32'h7FFFFFFF, 32'h80000000, 0, 48'hFFFF_0000_0001);
        send_query(32'h7FFFFFFF, 32'h12345678, 0);
        send_query(32'h7FFFFFFF, 32'h80000000, 32'h0000_00FF);
        send_query(32'h7FFF_0000, 32'h0, 32'h0000_0100);
        send_query(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
        end_burst();
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                idle_enable = 1'b0;
            end
            load_profile(rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word(),
                         {rand_inv(), rand_inv(), rand_inv()});
            if (ph == 3) begin
                stall_hold = 300;
            end
            for (int n = 0; n < 180; n++) begin
                if (ph == 5 && n == 90) begin
                    end_burst();
                    drain();
                end
                send_query(near_pos(0), near_pos(1), near_pos(2));
            end
            end_burst();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/gfp_eval_pkg.sv
hdl/gaussian_field_profile_evaluator_core.sv
hdl/gfp_eval_checker.sv
sim/testbench.sv
